// File: sv/mpct_pkg.sv
// mpct_pkg: shared types and constants of the mouse packet cursor tracker
`default_nettype none
package mpct_pkg;

   // position of a beat inside a three-byte packet
   typedef enum logic [1:0] {
      POS_STATUS = 2'd0,
      POS_DX     = 2'd1,
      POS_DY     = 2'd2
   } byte_pos_type;

   // event codes
   typedef enum logic [2:0] {
      EV_MOVE  = 3'd0,
      EV_LDOWN = 3'd1,
      EV_LUP   = 3'd2,
      EV_LDBL  = 3'd3,
      EV_RDOWN = 3'd4,
      EV_RUP   = 3'd5,
      EV_RDBL  = 3'd6
   } event_kind_type;

   // register indexes on the csr port
   localparam logic [1:0] REG_X_LIMIT = 2'd0;
   localparam logic [1:0] REG_Y_LIMIT = 2'd1;
   localparam logic [1:0] REG_DBL_WIN = 2'd2;

   // reset values of the registers
   localparam logic [15:0] X_LIMIT_RESET = 16'd639;
   localparam logic [15:0] Y_LIMIT_RESET = 16'd479;
   localparam logic [15:0] DBL_WIN_RESET = 16'd3;

   // status byte bits
   localparam int STAT_LEFT  = 0;
   localparam int STAT_RIGHT = 1;
   localparam int STAT_XNEG  = 4;
   localparam int STAT_YNEG  = 5;

   // position update of one axis: increase saturates at the limit
   typedef struct packed {
      logic [15:0] pos;
      logic [15:0] limit;
      logic [7:0]  delta;
      logic        grow;
   } axis_req_type;

endpackage
`default_nettype wire

// File: sv/mpct_axis.sv
// mpct_axis: one cursor axis update, saturating increase or floored decrease
`default_nettype none
module mpct_axis
   import mpct_pkg::*;
(
   input  axis_req_type req,
   output logic [15:0]  pos_next
);

   logic [16:0] sum;

   // wide sum so a high position never wraps
   assign sum = {1'b0, req.pos} + {9'd0, req.delta};

   // increase clamps to the limit, decrease floors at zero
   always_comb begin
      if (req.grow) begin
         pos_next = (sum >= {1'b0, req.limit}) ? req.limit : sum[15:0];
      end else begin
         pos_next = (req.pos >= {8'd0, req.delta}) ? (req.pos - {8'd0, req.delta}) : 16'd0;
      end
   end

endmodule
`default_nettype wire

// File: sv/mouse_packet_cursor_tracker.sv
// mouse_packet_cursor_tracker: mouse packet decoder with absolute cursor and click events
//
// Usage: mouse bytes enter on the req_ channel (req_mouse_byte with req_tick_now),
// in packets of status, dx, dy. Every beat is absorbed in the cycle it is
// accepted; the dy beat loads one event (kind, cursor x, cursor y) into the
// rsp_ output register, visible the cycle after acceptance.
// Status and dx beats produce no result.
// Throughput is one beat per cycle while req_ready is high: all decoding is one pass of adds,
// compares and flag logic between the state registers and the output register.
// When the receiver stalls with a result held, req_ready stays high only if
// that result is taken in the same cycle; status and dx beats are still taken
// only under the same ready, so at most one result is ever in flight.
// The csr_ APB port holds x_limit (0x0), y_limit (0x4) and
// double_click_window (0x8); write them only while the block is idle.
// Synchronous reset clears the packet position to expect a status byte,
// homes the cursor to zero, disarms both buttons and restores register
// defaults. No clearing pass is needed.
`default_nettype none
module mouse_packet_cursor_tracker
   import mpct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_mouse_byte,
   input  wire logic [31:0] req_tick_now,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic [15:0]      rsp_cursor_x,
   output logic [15:0]      rsp_cursor_y,
   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // registers
   logic [15:0]    x_limit_ff;
   logic [15:0]    y_limit_ff;
   logic [15:0]    dbl_win_ff;
   byte_pos_type   pos_ff, pos_in;
   logic [15:0]    pos_x_ff;
   logic [15:0]    pos_y_ff;
   logic           x_plus_ff;
   logic           y_plus_ff;
   logic [1:0]     buttons_now_ff;
   logic [1:0]     buttons_before_ff;
   logic [1:0]     armed_ff, armed_in;
   logic [31:0]    last_tick_ff, last_tick_in;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_kind_ff;
   logic [15:0]    rsp_x_ff;
   logic [15:0]    rsp_y_ff;

   logic           req_fire;
   logic           csr_write;
   logic [1:0]     csr_index;
   axis_req_type   x_req, y_req;
   logic [15:0]    x_next, y_next;
   event_kind_type kind_in;
   logic [1:0]     changed;
   logic [31:0]    tick_gap;
   logic           in_window;

   // handshake: take a beat unless a result is held and not taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_cursor_x   = rsp_x_ff;
   assign rsp_cursor_y   = rsp_y_ff;

   // csr decode
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_X_LIMIT: csr_prdata = {16'd0, x_limit_ff};
         REG_Y_LIMIT: csr_prdata = {16'd0, y_limit_ff};
         REG_DBL_WIN: csr_prdata = {16'd0, dbl_win_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
         dbl_win_ff <= DBL_WIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_X_LIMIT: x_limit_ff <= csr_pwdata[15:0];
            REG_Y_LIMIT: y_limit_ff <= csr_pwdata[15:0];
            REG_DBL_WIN: dbl_win_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // axis updates; a negative movement uses the complement of the byte
   always_comb begin
      x_req.pos   = pos_x_ff;
      x_req.limit = x_limit_ff;
      x_req.grow  = x_plus_ff;
      x_req.delta = x_plus_ff ? req_mouse_byte : ~req_mouse_byte;
      y_req.pos   = pos_y_ff;
      y_req.limit = y_limit_ff;
      y_req.grow  = !y_plus_ff;
      y_req.delta = y_plus_ff ? req_mouse_byte : ~req_mouse_byte;
   end

   mpct_axis u_axis_x (
      .req      (x_req),
      .pos_next (x_next)
   );

   mpct_axis u_axis_y (
      .req      (y_req),
      .pos_next (y_next)
   );

   // button events, left change wins over right change
   assign changed   = buttons_now_ff ^ buttons_before_ff;
   assign tick_gap  = req_tick_now - last_tick_ff;
   assign in_window = tick_gap <= {16'd0, dbl_win_ff};

   always_comb begin
      kind_in      = EV_MOVE;
      armed_in     = armed_ff;
      last_tick_in = last_tick_ff;
      priority if (changed[0]) begin
         if (buttons_before_ff[0]) begin
            kind_in = EV_LUP;
         end else if (armed_ff[0] && in_window) begin
            kind_in     = EV_LDBL;
            armed_in[0] = 1'b0;
         end else begin
            kind_in      = EV_LDOWN;
            armed_in[0]  = 1'b1;
            last_tick_in = req_tick_now;
         end
      end else if (changed[1]) begin
         if (buttons_before_ff[1]) begin
            kind_in = EV_RUP;
         end else if (armed_ff[1] && in_window) begin
            kind_in     = EV_RDBL;
            armed_in[1] = 1'b0;
         end else begin
            kind_in      = EV_RDOWN;
            armed_in[1]  = 1'b1;
            last_tick_in = req_tick_now;
         end
      end else begin
         kind_in = EV_MOVE;
      end
   end

   // packet position
   always_comb begin
      unique case (pos_ff)
         POS_STATUS: pos_in = POS_DX;
         POS_DX:     pos_in = POS_DY;
         POS_DY:     pos_in = POS_STATUS;
         default:    pos_in = POS_STATUS;
      endcase
   end

   // packet state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff            <= POS_STATUS;
         pos_x_ff          <= 16'd0;
         pos_y_ff          <= 16'd0;
         x_plus_ff         <= 1'b1;
         y_plus_ff         <= 1'b1;
         buttons_now_ff    <= 2'd0;
         buttons_before_ff <= 2'd0;
         armed_ff          <= 2'd0;
         last_tick_ff      <= 32'd0;
      end else if (req_fire) begin
         pos_ff <= pos_in;
         unique case (pos_ff)
            POS_STATUS: begin
               buttons_now_ff <= {req_mouse_byte[STAT_RIGHT], req_mouse_byte[STAT_LEFT]};
               x_plus_ff      <= !req_mouse_byte[STAT_XNEG];
               y_plus_ff      <= !req_mouse_byte[STAT_YNEG];
            end
            POS_DX: begin
               pos_x_ff <= x_next;
            end
            POS_DY: begin
               pos_y_ff          <= y_next;
               buttons_before_ff <= buttons_now_ff;
               armed_ff          <= armed_in;
               last_tick_ff      <= last_tick_in;
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && pos_ff == POS_DY) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && pos_ff == POS_DY) begin
         rsp_kind_ff <= kind_in;
         rsp_x_ff    <= pos_x_ff;
         rsp_y_ff    <= y_next;
      end
   end

   // a new result only follows an accepted dy beat
   a_rsp_from_dy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && pos_ff == POS_DY))
      else $error("result appeared without a dy beat");

   // status and dx beats leave the result register alone
   a_no_rsp_mid_packet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_ff != POS_DY) |=> rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready))
      else $error("result register changed on a mid-packet beat");

   // a double click disarms its button
   a_ldbl_disarms: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_ff == POS_DY && kind_in == EV_LDBL) |=> !armed_ff[0])
      else $error("left double click left the button armed");

   a_rdbl_disarms: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_ff == POS_DY && kind_in == EV_RDBL) |=> !armed_ff[1])
      else $error("right double click left the button armed");

endmodule
`default_nettype wire
